>>> hw/rtl/wsfd_pkg.sv
// shared types and constants for the websocket frame deframer
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_FLAGS,
    PH_LEN7,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  localparam int unsigned LEN_W       = 64;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned OUT_FIELD_W = 1 + 3 + 4 + 1 + LEN_W + 8;
  localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [CNT_W-1:0] EXT16_BYTES = 4'd2;
  localparam logic [CNT_W-1:0] EXT64_BYTES = 4'd8;
  localparam logic [CNT_W-1:0] KEY_BYTES   = 4'd4;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

endpackage

>>> hw/rtl/websocket_frame_deframer_top.sv
// websocket frame deframer: header parse, length decode and payload unmasking
//
// Takes one raw byte per transfer and produces at most one result per byte:
// a header summary on the byte that completes a frame header, then one
// unmasked payload byte per payload byte, with tlast on the frame's last
// byte (or on the header of an empty frame). Every byte is handled by the
// combinational parse logic and each result is registered in the output
// register, so the block sustains one byte per cycle; the input only
// stalls while a result sits in the output register and the sink holds
// out_tready low. The 64-bit payload countdown is the longest path.
module websocket_frame_deframer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // data_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // fin, reserved_bits[3], opcode[4], masked, frame_len[64],
  // data_out[8], zero fill
  output logic [wsfd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser,  // kind
  output logic                           out_tlast   // end_of_frame
);
  import wsfd_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [7:0]         flags_r, flags_nxt;
  logic               mask_r, mask_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [1:0]         kpos_r, kpos_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;

  logic               res_valid;
  logic               res_kind;
  logic [7:0]         res_flags;
  logic               res_mask;
  logic [LEN_W-1:0]   res_len;
  logic [7:0]         res_data;
  logic               res_last;

  logic               out_valid_r;
  logic               kind_r, fin_r, masked_r, last_r;
  logic [2:0]         rsv_r;
  logic [3:0]         opcode_r;
  logic [LEN_W-1:0]   plen_r;
  logic [7:0]         data_r;

  logic               accept;
  logic [6:0]         len7;
  logic [CNT_W-1:0]   left_dec;
  logic [LEN_W-1:0]   rem_dec;
  logic [7:0]         key_byte;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign len7     = in_tdata[6:0];
  assign left_dec = (left_r != '0) ? left_r - 1'b1 : '0;
  assign rem_dec  = (rem_r != '0) ? rem_r - 1'b1 : '0;

  always_comb begin
    case (kpos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    mask_nxt  = mask_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    key_nxt   = key_r;
    kpos_nxt  = kpos_r;
    rem_nxt   = rem_r;
    res_valid = 1'b0;
    res_kind  = KIND_HEADER;
    res_data  = 8'd0;
    res_last  = 1'b0;
    case (phase_r)
      PH_FLAGS: begin
        flags_nxt = in_tdata;
        phase_nxt = PH_LEN7;
      end
      PH_LEN7: begin
        mask_nxt = in_tdata[7];
        if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
          len_nxt   = '0;
          left_nxt  = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          phase_nxt = PH_EXTLEN;
        end else begin
          len_nxt = {{(LEN_W-7){1'b0}}, len7};
          key_nxt = '0;
          if (in_tdata[7]) begin
            left_nxt  = KEY_BYTES;
            phase_nxt = PH_KEY;
          end else begin
            res_valid = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        len_nxt  = {len_r[LEN_W-9:0], in_tdata};
        left_nxt = left_dec;
        if (left_dec == '0) begin
          key_nxt = '0;
          if (mask_r) begin
            left_nxt  = KEY_BYTES;
            phase_nxt = PH_KEY;
          end else begin
            res_valid = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_nxt  = {key_r[KEY_W-9:0], in_tdata};
        left_nxt = left_dec;
        if (left_dec == '0) begin
          res_valid = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        res_kind  = KIND_PAYLOAD;
        res_data  = mask_r ? (in_tdata ^ key_byte) : in_tdata;
        kpos_nxt  = kpos_r + 2'd1;
        rem_nxt   = rem_dec;
        if (rem_dec == '0) begin
          res_last  = 1'b1;
          phase_nxt = PH_FLAGS;
        end
      end
      default: begin
        phase_nxt = PH_FLAGS;
      end
    endcase
    // header completes: arm the payload countdown
    if (res_valid && res_kind == KIND_HEADER) begin
      kpos_nxt = 2'd0;
      rem_nxt  = len_nxt;
      if (len_nxt == '0) begin
        res_last  = 1'b1;
        phase_nxt = PH_FLAGS;
      end else begin
        phase_nxt = PH_PAYLOAD;
      end
    end
    res_flags = flags_nxt;
    res_mask  = mask_nxt;
    res_len   = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAGS;
      flags_r <= '0;
      mask_r  <= 1'b0;
      len_r   <= '0;
      left_r  <= '0;
      key_r   <= '0;
      kpos_r  <= '0;
      rem_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      mask_r  <= mask_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      key_r   <= key_nxt;
      kpos_r  <= kpos_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      kind_r   <= res_kind;
      fin_r    <= res_flags[7];
      rsv_r    <= res_flags[6:4];
      opcode_r <= res_flags[3:0];
      masked_r <= res_mask;
      plen_r   <= res_len;
      data_r   <= res_data;
      last_r   <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_FIELD_W){1'b0}},
                       data_r, plen_r, masked_r, opcode_r, rsv_r, fin_r};

endmodule
